### hdl/mpfd_pkg.sv
// mpfd_pkg: screen geometry, request codes and shared types of the page-mode frame store
// no dependencies; imported by every module of the block except mpfd_ram
`default_nettype none

package mpfd_pkg;

  localparam int SCREEN_W     = 128;
  localparam int SCREEN_PAGES = 8;
  localparam int SCREEN_ROWS  = SCREEN_PAGES * 8;
  localparam int STORE_BYTES  = SCREEN_W * SCREEN_PAGES;
  localparam int ADDR_W       = $clog2(STORE_BYTES);
  localparam int PG_W         = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;
  // coordinates up to an 8-bit origin plus an 8-bit span
  localparam int CW           = 9;
  localparam int SW           = CW + 1;

  localparam logic [7:0] BYTE_ONES = 8'hFF;
  localparam logic [2:0] BIT_LAST  = 3'd7;

  localparam logic [2:0] REQ_CLEAR   = 3'd0;
  localparam logic [2:0] REQ_PIXEL   = 3'd1;
  localparam logic [2:0] REQ_HLINE   = 3'd2;
  localparam logic [2:0] REQ_VLINE   = 3'd3;
  localparam logic [2:0] REQ_FILL    = 3'd4;
  localparam logic [2:0] REQ_OUTLINE = 3'd5;
  localparam logic [2:0] REQ_READ    = 3'd6;
  localparam logic [2:0] REQ_NONE    = 3'd7;

  // one rectangular region to paint, before clipping
  typedef struct packed {
    logic [CW-1:0] x0;
    logic [CW-1:0] y0;
    logic [CW-1:0] w;
    logic [CW-1:0] h;
    logic          on;
  } stroke_t;

  // single-address frame store access
  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

endpackage

`default_nettype wire

### hdl/mpfd_ram.sv
// mpfd_ram: generic single-port-write, single-port-read RAM with registered read data
// no dependencies
`default_nettype none

module mpfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire  logic                     clk_i,
  input  wire  logic                     wr_en_i,
  input  wire  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire  logic [WIDTH-1:0]         wr_data_i,
  input  wire  logic                     rd_en_i,
  input  wire  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic       [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

### hdl/mpfd_walker.sv
// mpfd_walker: clips one stroke and walks its bytes page by page, column by column,
// doing a read-modify-write per byte (plain write when the whole byte is covered)
// depends on mpfd_pkg
`default_nettype none

module mpfd_walker (
  input  wire  logic               clk_i,
  input  wire  logic               rst_ni,
  input  wire  logic               start_i,
  input  wire  mpfd_pkg::stroke_t  stroke_i,
  output logic                     done_o,
  output mpfd_pkg::mem_req_t       mem_o,
  input  wire  logic [7:0]         rdata_i
);
  import mpfd_pkg::*;

  typedef enum logic [1:0] {
    W_IDLE,
    W_ISSUE,
    W_MERGE
  } walk_e;

  walk_e            state_q, state_d;
  logic             done_q, done_d;
  logic [CW-1:0]    col_q, col_d;
  logic [CW-1:0]    xs_q, xs_d;
  logic [CW-1:0]    xl_q, xl_d;
  logic [PG_W-1:0]  page_q, page_d;
  logic [PG_W-1:0]  ps_q, ps_d;
  logic [PG_W-1:0]  pe_q, pe_d;
  logic [2:0]       ylo_q, ylo_d;
  logic [2:0]       yhi_q, yhi_d;
  logic             on_q, on_d;

  logic [SW-1:0]    xsum, ysum, xe, ye;
  logic [CW-1:0]    xl, yl;
  logic             empty;
  logic [2:0]       lo, hi;
  logic [7:0]       mask;
  logic [ADDR_W-1:0] addr;
  logic             step;

  // clipping at launch
  always_comb begin
    xsum  = SW'(stroke_i.x0) + SW'(stroke_i.w);
    ysum  = SW'(stroke_i.y0) + SW'(stroke_i.h);
    xe    = (xsum > SW'(SCREEN_W)) ? SW'(SCREEN_W) : xsum;
    ye    = (ysum > SW'(SCREEN_ROWS)) ? SW'(SCREEN_ROWS) : ysum;
    xl    = CW'(xe - SW'(1));
    yl    = CW'(ye - SW'(1));
    empty = (SW'(stroke_i.x0) >= SW'(SCREEN_W)) || (SW'(stroke_i.y0) >= SW'(SCREEN_ROWS)) ||
            (stroke_i.w == '0) || (stroke_i.h == '0);
  end

  // row mask inside the current page and byte address
  always_comb begin
    lo   = (page_q == ps_q) ? ylo_q : 3'd0;
    hi   = (page_q == pe_q) ? yhi_q : BIT_LAST;
    mask = (BYTE_ONES << lo) & (BYTE_ONES >> (BIT_LAST - hi));
    addr = ADDR_W'(32'(col_q) + 32'(page_q) * SCREEN_W);
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    col_d   = col_q;
    xs_d    = xs_q;
    xl_d    = xl_q;
    page_d  = page_q;
    ps_d    = ps_q;
    pe_d    = pe_q;
    ylo_d   = ylo_q;
    yhi_d   = yhi_q;
    on_d    = on_q;
    mem_o   = '0;
    step    = 1'b0;
    unique case (state_q)
      W_IDLE: begin
        if (start_i) begin
          col_d  = stroke_i.x0;
          xs_d   = stroke_i.x0;
          xl_d   = xl;
          page_d = PG_W'(stroke_i.y0 >> 3);
          ps_d   = PG_W'(stroke_i.y0 >> 3);
          pe_d   = PG_W'(yl >> 3);
          ylo_d  = stroke_i.y0[2:0];
          yhi_d  = yl[2:0];
          on_d   = stroke_i.on;
          if (empty) begin
            done_d = 1'b1;
          end else begin
            state_d = W_ISSUE;
          end
        end
      end
      W_ISSUE: begin
        mem_o.addr = addr;
        if (mask == BYTE_ONES) begin
          mem_o.wr_en = 1'b1;
          mem_o.wdata = on_q ? BYTE_ONES : 8'h00;
          step        = 1'b1;
        end else begin
          mem_o.rd_en = 1'b1;
          state_d     = W_MERGE;
        end
      end
      W_MERGE: begin
        mem_o.addr  = addr;
        mem_o.wr_en = 1'b1;
        mem_o.wdata = (rdata_i & ~mask) | (on_q ? mask : 8'h00);
        state_d     = W_ISSUE;
        step        = 1'b1;
      end
      default: begin
        state_d = W_IDLE;
      end
    endcase
    if (step) begin
      if (col_q == xl_q) begin
        col_d = xs_q;
        if (page_q == pe_q) begin
          state_d = W_IDLE;
          done_d  = 1'b1;
        end else begin
          page_d = page_q + PG_W'(1);
        end
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q  <= col_d;
    xs_q   <= xs_d;
    xl_q   <= xl_d;
    page_q <= page_d;
    ps_q   <= ps_d;
    pe_q   <= pe_d;
    ylo_q  <= ylo_d;
    yhi_q  <= yhi_d;
    on_q   <= on_d;
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

### hdl/mono_page_framebuffer_draw.sv
// mono_page_framebuffer_draw: page-organized monochrome frame store with drawing requests
// depends on mpfd_pkg, mpfd_ram, mpfd_walker
//
//   channel | direction | handshake             | payload
//   request | in        | in_valid_i/in_stall_o  | req_type, pos_x, pos_y, span_w, span_h,
//           |           |                        | pix_on, byte_index
//   result  | out       | out_valid_o/out_stall_i| read_byte, req_echo
//
// one request at a time; the walker touches one frame store byte per cycle when the
// whole byte is covered, and does a read then a merge-write otherwise
// clear: one pass over the whole store; fill rect: every column of every page touched;
// outline: four strokes back to back; read byte: one store read, then result handoff
// after reset a clearing pass runs with in_stall_o high
// a stalled result does not block the next request; it finishes and waits in its last state
`default_nettype none

module mono_page_framebuffer_draw (
  input  wire  logic       clk_i,
  input  wire  logic       rst_ni,
  input  wire  logic       in_valid_i,
  output logic             in_stall_o,
  input  wire  logic [2:0] req_type_i,
  input  wire  logic [7:0] pos_x_i,
  input  wire  logic [7:0] pos_y_i,
  input  wire  logic [7:0] span_w_i,
  input  wire  logic [7:0] span_h_i,
  input  wire  logic       pix_on_i,
  input  wire  logic [9:0] byte_index_i,
  output logic             out_valid_o,
  input  wire  logic       out_stall_i,
  output logic [7:0]       read_byte_o,
  output logic [2:0]       req_echo_o
);
  import mpfd_pkg::*;

  typedef enum logic [2:0] {
    T_CLR_GO,
    T_CLR_WAIT,
    T_IDLE,
    T_LAUNCH,
    T_WALK,
    T_READ,
    T_FIN
  } top_e;

  top_e       state_q, state_d;
  logic [1:0] sidx_q, sidx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] rb_q, rb_d;
  logic [2:0] echo_q, echo_d;

  logic [2:0] kind_q;
  logic [7:0] x_q, y_q, w_q, h_q;
  logic       on_q;
  logic [9:0] idx_q;

  stroke_t    stroke;
  logic [1:0] last_sidx;
  logic       walk_start, walk_done;
  mem_req_t   walk_req, ram_req;
  logic [7:0] ram_rdata;
  logic       in_range, slot_free;

  // stroke selection
  always_comb begin
    stroke.x0 = CW'(x_q);
    stroke.y0 = CW'(y_q);
    stroke.w  = CW'(1);
    stroke.h  = CW'(1);
    stroke.on = on_q;
    last_sidx = 2'd0;
    if (state_q == T_CLR_GO || kind_q == REQ_CLEAR) begin
      stroke.x0 = '0;
      stroke.y0 = '0;
      stroke.w  = CW'(SCREEN_W);
      stroke.h  = CW'(SCREEN_ROWS);
      stroke.on = 1'b0;
    end else begin
      priority case (kind_q)
        REQ_HLINE: stroke.w = CW'(w_q);
        REQ_VLINE: stroke.h = CW'(h_q);
        REQ_FILL: begin
          stroke.w = CW'(w_q);
          stroke.h = CW'(h_q);
        end
        REQ_OUTLINE: begin
          last_sidx = 2'd3;
          unique case (sidx_q)
            2'd0: stroke.w = CW'(w_q);
            2'd1: begin
              stroke.y0 = CW'(y_q) + CW'(h_q);
              stroke.w  = CW'(w_q);
            end
            2'd2: stroke.h = CW'(h_q);
            default: begin
              stroke.x0 = CW'(x_q) + CW'(w_q);
              stroke.h  = CW'(h_q);
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  assign walk_start = (state_q == T_CLR_GO) || (state_q == T_LAUNCH);
  assign in_range   = 32'(idx_q) < STORE_BYTES;
  assign slot_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    ram_req = walk_req;
    if (state_q == T_READ) begin
      ram_req       = '0;
      ram_req.rd_en = 1'b1;
      ram_req.addr  = ADDR_W'(idx_q);
    end
  end

  always_comb begin
    state_d     = state_q;
    sidx_d      = sidx_q;
    out_valid_d = out_valid_q && out_stall_i;
    rb_d        = rb_q;
    echo_d      = echo_q;
    unique case (state_q)
      T_CLR_GO:   state_d = T_CLR_WAIT;
      T_CLR_WAIT: if (walk_done) state_d = T_IDLE;
      T_IDLE: begin
        if (in_valid_i) begin
          sidx_d = 2'd0;
          priority case (req_type_i)
            REQ_READ: state_d = T_READ;
            REQ_NONE: state_d = T_FIN;
            default:  state_d = T_LAUNCH;
          endcase
        end
      end
      T_LAUNCH: state_d = T_WALK;
      T_WALK: begin
        if (walk_done) begin
          if (sidx_q == last_sidx) begin
            state_d = T_FIN;
          end else begin
            sidx_d  = sidx_q + 2'd1;
            state_d = T_LAUNCH;
          end
        end
      end
      T_READ: state_d = T_FIN;
      T_FIN: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          rb_d        = (kind_q == REQ_READ && in_range) ? ram_rdata : 8'h00;
          echo_d      = kind_q;
          state_d     = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_CLR_GO;
      sidx_q      <= 2'd0;
      out_valid_q <= 1'b0;
      rb_q        <= 8'h00;
      echo_q      <= 3'd0;
    end else begin
      state_q     <= state_d;
      sidx_q      <= sidx_d;
      out_valid_q <= out_valid_d;
      rb_q        <= rb_d;
      echo_q      <= echo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == T_IDLE && in_valid_i) begin
      kind_q <= req_type_i;
      x_q    <= pos_x_i;
      y_q    <= pos_y_i;
      w_q    <= span_w_i;
      h_q    <= span_h_i;
      on_q   <= pix_on_i;
      idx_q  <= byte_index_i;
    end
  end

  mpfd_walker u_walker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (walk_start),
    .stroke_i (stroke),
    .done_o   (walk_done),
    .mem_o    (walk_req),
    .rdata_i  (ram_rdata)
  );

  mpfd_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (ram_req.wr_en),
    .wr_addr_i (ram_req.addr),
    .wr_data_i (ram_req.wdata),
    .rd_en_i   (ram_req.rd_en),
    .rd_addr_i (ram_req.addr),
    .rd_data_o (ram_rdata)
  );

  assign in_stall_o  = (state_q != T_IDLE);
  assign out_valid_o = out_valid_q;
  assign read_byte_o = rb_q;
  assign req_echo_o  = echo_q;

endmodule

`default_nettype wire

### hdl/mpfd_chk.sv
// mpfd_chk: port-level checks for mono_page_framebuffer_draw, bound to the top level
// depends on mpfd_pkg
`default_nettype none

module mpfd_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] read_byte_o,
  input wire logic [2:0] req_echo_o
);
  import mpfd_pkg::*;

  // one request in flight: a taken request closes the input
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input open right after a request was taken");

  // clearing pass keeps the input closed right after reset
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> in_stall_o)
    else $error("input open during the reset clearing pass");

  // only reads return data
  a_zero_for_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && req_echo_o != REQ_READ) |-> (read_byte_o == 8'h00))
    else $error("nonzero byte on a non-read result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(read_byte_o) && $stable(req_echo_o)))
    else $error("stalled result changed");

endmodule

bind mono_page_framebuffer_draw mpfd_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .read_byte_o (read_byte_o),
  .req_echo_o  (req_echo_o)
);

`default_nettype wire

### tb/tb_mono_page_framebuffer_draw.sv
// tb_mono_page_framebuffer_draw: self-checking testbench for the page-mode frame store
// keeps its own pixel map, predicts every read-back and request echo; needs mpfd_pkg
// and mono_page_framebuffer_draw
module tb_mono_page_framebuffer_draw;
  import mpfd_pkg::*;

  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 500;
  localparam int TAIL_CYCLES = 2100;

  // shadow copy of the frame store plus the queue of results still owed
  class draw_scoreboard;
    bit [7:0] pixels [STORE_BYTES];
    logic [7:0] owed_byte [$];
    logic [2:0] owed_kind [$];
    int errors;
    int checked;
    int kind_seen [8];

    function void put_px(int col, int row, bit on);
      int a;
      if (col >= SCREEN_W || row >= SCREEN_ROWS) return;
      a = col + (row / 8) * SCREEN_W;
      pixels[a][row % 8] = on;
    endfunction

    function void run_h(int col, int row, int len, bit on);
      if (col >= SCREEN_W) return;
      if (col + len > SCREEN_W) len = SCREEN_W - col;
      for (int i = 0; i < len; i++) put_px(col + i, row, on);
    endfunction

    function void run_v(int col, int row, int len, bit on);
      if (row >= SCREEN_ROWS) return;
      if (row + len > SCREEN_ROWS) len = SCREEN_ROWS - row;
      for (int i = 0; i < len; i++) put_px(col, row + i, on);
    endfunction

    function void note_request(logic [2:0] kind, int x, int y, int w, int h, bit on,
                               int idx);
      logic [7:0] rd;
      rd = 8'h00;
      kind_seen[kind]++;
      case (kind)
        REQ_CLEAR: begin
          foreach (pixels[i]) pixels[i] = 8'h00;
        end
        REQ_PIXEL: put_px(x, y, on);
        REQ_HLINE: run_h(x, y, w, on);
        REQ_VLINE: run_v(x, y, h, on);
        REQ_FILL: begin
          for (int i = 0; i < w; i++) run_v(x + i, y, h, on);
        end
        REQ_OUTLINE: begin
          run_h(x, y, w, on);
          run_h(x, y + h, w, on);
          run_v(x, y, h, on);
          run_v(x + w, y, h, on);
        end
        REQ_READ: begin
          if (idx < STORE_BYTES) rd = pixels[idx];
        end
        default: ;
      endcase
      owed_byte.push_back(rd);
      owed_kind.push_back(kind);
    endfunction

    function void check_result(logic [7:0] rd, logic [2:0] kind);
      logic [7:0] want_rd;
      logic [2:0] want_kind;
      if (owed_kind.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual read_byte %0h req_echo %0d",
                 $time, rd, kind);
        errors++;
        return;
      end
      want_rd = owed_byte.pop_front();
      want_kind = owed_kind.pop_front();
      checked++;
      if (rd !== want_rd) begin
        $display("%0t: read_byte expected %0h actual %0h", $time, want_rd, rd);
        errors++;
      end
      if (kind !== want_kind) begin
        $display("%0t: req_echo expected %0d actual %0d", $time, want_kind, kind);
        errors++;
      end
    endfunction

    function int outstanding();
      return owed_kind.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] req_type;
  logic [7:0] pos_x;
  logic [7:0] pos_y;
  logic [7:0] span_w;
  logic [7:0] span_h;
  logic       pix_on;
  logic [9:0] byte_index;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] read_byte;
  logic [2:0] req_echo;

  draw_scoreboard sb = new;
  bit calm;
  bit hold_pending;
  int quiet_cycles;
  int hint_idx;

  mono_page_framebuffer_draw u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .req_type_i  (req_type),
    .pos_x_i     (pos_x),
    .pos_y_i     (pos_y),
    .span_w_i    (span_w),
    .span_h_i    (span_h),
    .pix_on_i    (pix_on),
    .byte_index_i(byte_index),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .read_byte_o (read_byte),
    .req_echo_o  (req_echo)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_request(req_type, int'(pos_x), int'(pos_y), int'(span_w), int'(span_h),
                        pix_on, int'(byte_index));
      end
      if (out_valid && !out_stall) begin
        sb.check_result(read_byte, req_echo);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // result side: random stall bursts, one long hold on request, none when calm
  initial begin : result_side
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        n = HOLD_CYCLES;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 18);
      end else begin
        out_stall <= 1'b0;
        n = calm ? 1 : $urandom_range(1, 40);
      end
      repeat (n) @(posedge clk);
    end
  end

  task automatic send_request(input logic [2:0] k, input logic [7:0] x, input logic [7:0] y,
                              input logic [7:0] w, input logic [7:0] h, input logic on,
                              input logic [9:0] idx);
    in_valid   <= 1'b1;
    req_type   <= k;
    pos_x      <= x;
    pos_y      <= y;
    span_w     <= w;
    span_h     <= h;
    pix_on     <= on;
    byte_index <= idx;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic pause_cycles(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  function automatic logic [7:0] pick_coord(input int limit);
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return 8'($urandom_range(0, limit - 1));
    if (r < 17) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'(limit - 1);
      2: return 8'(limit);
      default: return 8'hFF;
    endcase
  endfunction

  function automatic logic [7:0] pick_span();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 8'($urandom_range(0, 16));
    if (r < 9) return 8'($urandom_range(0, 80));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic random_request();
    logic [2:0] k;
    logic [7:0] x, y, w, h;
    logic [9:0] idx;
    logic on;
    int r, col, row;
    r = $urandom_range(0, 99);
    if (r < 30)      k = REQ_READ;
    else if (r < 45) k = REQ_PIXEL;
    else if (r < 57) k = REQ_HLINE;
    else if (r < 69) k = REQ_VLINE;
    else if (r < 82) k = REQ_FILL;
    else if (r < 94) k = REQ_OUTLINE;
    else if (r < 96) k = REQ_CLEAR;
    else             k = REQ_NONE;
    x = pick_coord(SCREEN_W);
    y = pick_coord(SCREEN_ROWS);
    w = pick_span();
    h = pick_span();
    on = ($urandom_range(0, 9) < 7);
    if (k == REQ_READ && $urandom_range(0, 1)) idx = 10'(hint_idx);
    else idx = 10'($urandom_range(0, 1023));
    if (k != REQ_READ && k != REQ_CLEAR && k != REQ_NONE) begin
      col = (x + $urandom_range(0, w)) % SCREEN_W;
      row = (y + $urandom_range(0, h)) % SCREEN_ROWS;
      hint_idx = col + (row / 8) * SCREEN_W;
    end
    send_request(k, x, y, w, h, on, idx);
  endtask

  task automatic random_phase(input int count);
    bit gappy;
    gappy = 1'b1;
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) gappy = 1'($urandom_range(0, 1));
      random_request();
      if (!calm && gappy && $urandom_range(0, 3) == 0) pause_cycles($urandom_range(1, 18));
    end
  endtask

  initial begin
    calm = 1'b0;
    hold_pending = 1'b0;
    hint_idx = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    req_type <= REQ_CLEAR;
    pos_x <= 8'd0;
    pos_y <= 8'd0;
    span_w <= 8'd0;
    span_h <= 8'd0;
    pix_on <= 1'b0;
    byte_index <= 10'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // corners, clipping, off-screen origins, zero spans, outline corner
    send_request(REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 10'd0);
    send_request(REQ_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 10'd0);
    send_request(REQ_PIXEL, 8'd127, 8'd63, 8'd0, 8'd0, 1'b1, 10'd0);
    send_request(REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 10'd0);
    send_request(REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 10'd1023);
    send_request(REQ_PIXEL, 8'd128, 8'd5, 8'd0, 8'd0, 1'b1, 10'd0);
    send_request(REQ_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 10'd1023);
    send_request(REQ_HLINE, 8'd120, 8'd10, 8'd255, 8'd0, 1'b1, 10'd0);
    send_request(REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 10'd255);
    send_request(REQ_VLINE, 8'd5, 8'd60, 8'd0, 8'd255, 1'b1, 10'd0);
    send_request(REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 10'd901);
    send_request(REQ_HLINE, 8'd10, 8'd20, 8'd0, 8'd9, 1'b1, 10'd0);
    send_request(REQ_VLINE, 8'd10, 8'd20, 8'd9, 8'd0, 1'b1, 10'd0);
    send_request(REQ_FILL, 8'd30, 8'd30, 8'd0, 8'd40, 1'b1, 10'd0);
    send_request(REQ_FILL, 8'd0, 8'd0, 8'd255, 8'd255, 1'b1, 10'd0);
    send_request(REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 10'd500);
    send_request(REQ_OUTLINE, 8'd10, 8'd10, 8'd20, 8'd20, 1'b0, 10'd0);
    send_request(REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 10'd414);
    send_request(REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 10'd158);
    send_request(REQ_NONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 10'h3FF);
    send_request(REQ_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 10'd0);
    send_request(REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 10'd500);
    send_request(REQ_OUTLINE, 8'd250, 8'd250, 8'd255, 8'd255, 1'b1, 10'd0);
    send_request(REQ_OUTLINE, 8'd100, 8'd40, 8'd255, 8'd255, 1'b1, 10'd0);
    send_request(REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 10'd740);
    wait_drained();

    random_phase(700);
    wait_drained();

    // back up the block behind a stalled result
    hold_pending = 1'b1;
    for (int n = 0; n < 12; n++) random_request();

    random_phase(750);
    wait_drained();

    calm = 1'b1;
    random_phase(200);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d clear, %0d pixel, %0d hline, %0d vline, %0d fill, %0d outline,",
             sb.kind_seen[REQ_CLEAR], sb.kind_seen[REQ_PIXEL], sb.kind_seen[REQ_HLINE],
             sb.kind_seen[REQ_VLINE], sb.kind_seen[REQ_FILL], sb.kind_seen[REQ_OUTLINE]);
    $display("%0d read and %0d unused-code requests; %0d results checked",
             sb.kind_seen[REQ_READ], sb.kind_seen[REQ_NONE], sb.checked);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
